### rtl/core/klut_pkg.sv
// ----------------------------------------------------------------------------
// klut_pkg
// Shared types and constants for the K line UART transceiver.
// ----------------------------------------------------------------------------
package klut_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 20;
  localparam int unsigned CFG_W          = 20;
  localparam int unsigned PERIOD_W       = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned BITCNT_W       = 4;
  localparam int unsigned APB_AW         = 5;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HIGH     = 3'd4;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST    = 16'd96;
  localparam logic [CFG_W-1:0]    REPLY_TIMEOUT_RST = 20'd50000;
  localparam logic [CFG_W-1:0]    IDLE_FIRST_RST    = 20'd300000;
  localparam logic [CFG_W-1:0]    WAKE_LOW_RST      = 20'd25000;
  localparam logic [CFG_W-1:0]    WAKE_HIGH_RST     = 20'd25000;

  // bit counter marks: frame of start, eight data and stop
  localparam logic [BITCNT_W-1:0] TX_BITS_START = 4'd10;
  localparam logic [BITCNT_W-1:0] RX_BITS_START = 4'd11;
  localparam logic [BITCNT_W-1:0] BITS_START_CHK = 4'd10;
  localparam logic [BITCNT_W-1:0] BITS_DATA_LO  = 4'd2;
  localparam logic [BITCNT_W-1:0] BITS_STOP     = 4'd1;
  localparam logic [BYTE_W-1:0]   RX_MSB        = 8'h80;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_RECV  = 2'd2,
    REQ_WAKE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUS_ERROR = 2'd1,
    ST_NO_DATA   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_TX        = 3'd1,
    MODE_RX        = 3'd2,
    MODE_WAKE_IDLE = 3'd3,
    MODE_WAKE_LOW  = 3'd4,
    MODE_WAKE_HIGH = 3'd5
  } op_mode_e;

endpackage

### rtl/core/klut_if.sv
// ----------------------------------------------------------------------------
// klut_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface klut_req_if import klut_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [BYTE_W-1:0] tx_byte;
  logic              k_sample;

  modport source (output valid, req_type, tx_byte, k_sample, input ready);
  modport sink   (input valid, req_type, tx_byte, k_sample, output ready);
endinterface

interface klut_res_if import klut_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              k_level;
  logic              l_level;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic [1:0]        status;

  modport source (output valid, k_level, l_level, busy_res, done_res, rx_byte, status,
                  input ready);
  modport sink   (input valid, k_level, l_level, busy_res, done_res, rx_byte, status,
                  output ready);
endinterface

### rtl/core/kline_uart_transceiver_unit.sv
// Each accepted item's result item is registered and valid in the next cycle.
// Throughput: one item per cycle while no result item is stalled; the whole state update for a tick is a single
// registered pass (one tick counter increment and one length compare).
// A stalled result item holds back the input side until it is taken.
// Reset (rst_ni low, asynchronous): idle, lines released high, status ok,
// configuration registers at their defaults.
// ----------------------------------------------------------------------------
// kline_uart_transceiver_unit
// Half-duplex K line UART (8N1) with L line wake-up pattern and APB setup.
// ----------------------------------------------------------------------------
module kline_uart_transceiver_unit import klut_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  klut_req_if.sink          req_i,
  klut_res_if.source        res_o
);

  localparam int unsigned CW = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam logic [CW-1:0] TMAX = CW'((64'd1 << TICK_WIDTH) - 64'd1);
  localparam logic [TICK_WIDTH-1:0] TMAX_T = TMAX[TICK_WIDTH-1:0];

  // configuration
  logic [PERIOD_W-1:0] bit_period_q;
  logic [CFG_W-1:0]    reply_timeout_q, idle_first_q, wake_low_q, wake_high_q;
  logic                cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q    <= BIT_PERIOD_RST;
      reply_timeout_q <= REPLY_TIMEOUT_RST;
      idle_first_q    <= IDLE_FIRST_RST;
      wake_low_q      <= WAKE_LOW_RST;
      wake_high_q     <= WAKE_HIGH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_BIT_PERIOD:    bit_period_q    <= pwdata[PERIOD_W-1:0];
        CFG_REPLY_TIMEOUT: reply_timeout_q <= pwdata[CFG_W-1:0];
        CFG_IDLE_FIRST:    idle_first_q    <= pwdata[CFG_W-1:0];
        CFG_WAKE_LOW:      wake_low_q      <= pwdata[CFG_W-1:0];
        CFG_WAKE_HIGH:     wake_high_q     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_BIT_PERIOD:    prdata = APB_DW'(bit_period_q);
      CFG_REPLY_TIMEOUT: prdata = APB_DW'(reply_timeout_q);
      CFG_IDLE_FIRST:    prdata = APB_DW'(idle_first_q);
      CFG_WAKE_LOW:      prdata = APB_DW'(wake_low_q);
      CFG_WAKE_HIGH:     prdata = APB_DW'(wake_high_q);
      default:           prdata = '0;
    endcase
  end

  // transceiver state
  op_mode_e              mode_q, mode_d;
  logic [BITCNT_W-1:0]   bitcnt_q, bitcnt_d, bitcnt_dec;
  logic [BYTE_W-1:0]     shift_q, shift_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d, tick_inc;
  logic                  rx_wait_q, rx_wait_d;
  logic                  prev_k_q;
  logic                  k_drv_q, k_drv_d, l_drv_q, l_drv_d;
  status_e               status_q, status_d;
  logic                  done;
  logic [BYTE_W-1:0]     rx_out;

  logic [CW-1:0] len_raw, len_c;
  logic          hit;
  logic          accept, res_load;
  logic          k_in;
  logic [1:0]    req;

  assign res_load = !res_o.valid || res_o.ready;
  assign req_i.ready = res_load;
  assign accept = req_i.valid && res_load;
  assign k_in = req_i.k_sample;
  assign req  = req_i.req_type;
  assign bitcnt_dec = bitcnt_q - BITCNT_W'(1);

  always_comb begin
    unique case (mode_q)
      MODE_TX:        len_raw = CW'(bit_period_q);
      MODE_RX: begin
        if (rx_wait_q) begin
          len_raw = CW'(reply_timeout_q);
        end else if (bitcnt_q == RX_BITS_START) begin
          len_raw = CW'(bit_period_q >> 1);
        end else begin
          len_raw = CW'(bit_period_q);
        end
      end
      MODE_WAKE_IDLE: len_raw = CW'(idle_first_q);
      MODE_WAKE_LOW:  len_raw = CW'(wake_low_q);
      MODE_WAKE_HIGH: len_raw = CW'(wake_high_q);
      default:        len_raw = '0;
    endcase
  end

  assign len_c    = (len_raw > TMAX) ? TMAX : len_raw;
  assign tick_inc = (tick_q < TMAX_T) ? tick_q + TICK_WIDTH'(1) : tick_q;
  assign hit      = CW'(tick_inc) >= len_c;

  always_comb begin
    mode_d    = mode_q;
    bitcnt_d  = bitcnt_q;
    shift_d   = shift_q;
    tick_d    = tick_q;
    rx_wait_d = rx_wait_q;
    k_drv_d   = k_drv_q;
    l_drv_d   = l_drv_q;
    status_d  = status_q;
    done      = 1'b0;
    rx_out    = '0;

    if (mode_q == MODE_IDLE) begin
      if (req != REQ_TICK) begin
        tick_d   = '0;
        status_d = ST_OK;
        case (req)
          REQ_SEND: begin
            mode_d   = MODE_TX;
            shift_d  = req_i.tx_byte;
            bitcnt_d = TX_BITS_START;
            k_drv_d  = 1'b0;
          end
          REQ_RECV: begin
            mode_d    = MODE_RX;
            rx_wait_d = 1'b1;
            shift_d   = '0;
            bitcnt_d  = '0;
          end
          default: mode_d = MODE_WAKE_IDLE;
        endcase
      end
    end else begin
      unique case (mode_q)
        MODE_TX: begin
          tick_d = tick_inc;
          if (hit) begin
            tick_d   = '0;
            bitcnt_d = bitcnt_dec;
            if (bitcnt_dec >= BITS_DATA_LO && bitcnt_dec < TX_BITS_START) begin
              k_drv_d = shift_q[0];
              shift_d = shift_q >> 1;
            end else if (bitcnt_dec == BITS_STOP) begin
              k_drv_d = 1'b1;
            end else begin
              k_drv_d  = 1'b1;
              mode_d   = MODE_IDLE;
              status_d = ST_OK;
              done     = 1'b1;
            end
          end
        end
        MODE_RX: begin
          if (rx_wait_q) begin
            if (prev_k_q && !k_in) begin
              rx_wait_d = 1'b0;
              tick_d    = '0;
              bitcnt_d  = RX_BITS_START;
              shift_d   = '0;
            end else begin
              tick_d = tick_inc;
              if (hit) begin
                rx_wait_d = 1'b0;
                mode_d    = MODE_IDLE;
                status_d  = ST_NO_DATA;
                shift_d   = '0;
                done      = 1'b1;
              end
            end
          end else begin
            tick_d = tick_inc;
            if (hit) begin
              tick_d   = '0;
              bitcnt_d = bitcnt_dec;
              if (bitcnt_dec >= BITS_START_CHK) begin
                if (k_in) begin
                  mode_d   = MODE_IDLE;
                  status_d = ST_BUS_ERROR;
                  shift_d  = '0;
                  done     = 1'b1;
                end
              end else if (bitcnt_dec >= BITS_DATA_LO) begin
                shift_d = (shift_q >> 1) | (k_in ? RX_MSB : '0);
              end else begin
                mode_d   = MODE_IDLE;
                status_d = k_in ? ST_OK : ST_BUS_ERROR;
                done     = 1'b1;
              end
            end
          end
          if (done) begin
            rx_out = shift_d;
          end
        end
        MODE_WAKE_IDLE: begin
          if (!k_in ? (len_c == '0) : hit) begin
            tick_d  = '0;
            k_drv_d = 1'b0;
            l_drv_d = 1'b0;
            mode_d  = MODE_WAKE_LOW;
          end else begin
            tick_d = k_in ? tick_inc : '0;
          end
        end
        MODE_WAKE_LOW: begin
          tick_d = tick_inc;
          if (hit) begin
            tick_d  = '0;
            k_drv_d = 1'b1;
            l_drv_d = 1'b1;
            mode_d  = MODE_WAKE_HIGH;
          end
        end
        MODE_WAKE_HIGH: begin
          tick_d = tick_inc;
          if (hit) begin
            tick_d   = '0;
            mode_d   = MODE_IDLE;
            status_d = ST_OK;
            done     = 1'b1;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      bitcnt_q  <= '0;
      shift_q   <= '0;
      tick_q    <= '0;
      rx_wait_q <= 1'b0;
      prev_k_q  <= 1'b1;
      k_drv_q   <= 1'b1;
      l_drv_q   <= 1'b1;
      status_q  <= ST_OK;
    end else if (accept) begin
      mode_q    <= mode_d;
      bitcnt_q  <= bitcnt_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      rx_wait_q <= rx_wait_d;
      prev_k_q  <= k_in;
      k_drv_q   <= k_drv_d;
      l_drv_q   <= l_drv_d;
      status_q  <= status_d;
    end
  end

  // result register
  logic res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_o.k_level  <= k_drv_d;
      res_o.l_level  <= l_drv_d;
      res_o.busy_res <= (mode_d != MODE_IDLE);
      res_o.done_res <= done;
      res_o.rx_byte  <= rx_out;
      res_o.status   <= status_d;
    end
  end

  assign res_o.valid = res_valid_q;

endmodule

### rtl/core/klut_checker.sv
// ----------------------------------------------------------------------------
// klut_checker
// Port-level checks on the result channel of the transceiver.
// ----------------------------------------------------------------------------
module klut_checker import klut_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid,
  input logic              res_ready,
  input logic              busy,
  input logic              done,
  input logic [BYTE_W-1:0] rx_byte,
  input logic [1:0]        status
);

  // stalled result item keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(rx_byte) && $stable(status)
      && $stable(done) && $stable(busy))
    else $error("result item changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && done |-> !busy)
    else $error("done reported while still busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> status == ST_OK || status == ST_BUS_ERROR || status == ST_NO_DATA)
    else $error("illegal status code");

  a_rx_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && rx_byte != '0 |-> done)
    else $error("received byte shown without done");

endmodule

bind kline_uart_transceiver_unit klut_checker u_klut_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .busy      (res_o.busy_res),
  .done      (res_o.done_res),
  .rx_byte   (res_o.rx_byte),
  .status    (res_o.status)
);
